>>> rtl/npr_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the Newton root finder.
`default_nettype none
package npr_pkg;
	// Word format: signed Q16.16
	localparam int W = 32;
	localparam int F = 16;
	localparam int DW = W + F;   // width of the scaled dividend and of the quotient
	localparam int DEG = 4;      // polynomial degree
	localparam int CNT_W = 8;    // width of the iteration counter

	typedef logic signed [W-1:0] word_t;

	localparam word_t MAXV = {1'b0, {(W-1){1'b1}}};
	localparam word_t MINV = {1'b1, {(W-1){1'b0}}};

	// Configuration register indexes
	localparam logic [2:0] REG_COEF0 = 3'd0;
	localparam logic [2:0] REG_COEF1 = 3'd1;
	localparam logic [2:0] REG_COEF2 = 3'd2;
	localparam logic [2:0] REG_COEF3 = 3'd3;
	localparam logic [2:0] REG_COEF4 = 3'd4;
	localparam logic [2:0] REG_MAXIT = 3'd5;
	localparam logic [2:0] REG_TOL = 3'd6;
	localparam logic [2:0] REG_FLOOR = 3'd7;

	// Result status codes
	typedef enum logic [1:0] {
		ST_CONV = 2'd0,
		ST_FLAT = 2'd1,
		ST_LEFT = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

	// Multiply-add unit operations
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_LOAD = 2'd1,
		OP_MUL = 2'd2,
		OP_ADD = 2'd3
	} mac_op_t;

	typedef struct packed {
		mac_op_t op;
		word_t coef;
	} mac_req_t;

	// Clamp a two-bit-wider signed value to the word range
	function automatic word_t clamp_wide(input logic signed [W+1:0] v);
		word_t r;
		if (v > (W+2)'(MAXV)) r = MAXV;
		else if (v < (W+2)'(MINV)) r = MINV;
		else r = v[W-1:0];
		return r;
	endfunction

	// Magnitude of a signed word; the most negative value maps to 2^(W-1)
	function automatic logic [W-1:0] mag_of(input word_t v);
		logic [W-1:0] r;
		r = v[W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

	// Signed word from sign and magnitude, with saturation
	function automatic word_t from_mag(input logic neg, input logic [DW-1:0] m);
		word_t r;
		if (neg) begin
			if (m >= DW'({1'b1, {(W-1){1'b0}}})) r = MINV;
			else r = ~m[W-1:0] + 1'b1;
		end else begin
			if (m > DW'(MAXV)) r = MAXV;
			else r = m[W-1:0];
		end
		return r;
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [W+1:0] s;
		s = (W+2)'(a) + (W+2)'(b);
		return clamp_wide(s);
	endfunction
endpackage
`default_nettype wire

>>> rtl/npr_mac.sv
// Shared saturating multiply and add unit used for Horner evaluation.
`default_nettype none
module npr_mac
	import npr_pkg::*;
(
	input wire logic clk,
	input wire mac_req_t req,
	input wire word_t x,
	output word_t acc
);
	logic [2*W-1:0] mprod;
	word_t mul_res;
	word_t prod_q;
	word_t acc_q;

	// Product of magnitudes, scaled back by the fraction bits, truncated toward zero
	always_comb begin
		mprod = (2*W)'(mag_of(acc_q)) * (2*W)'(mag_of(x));
		mul_res = from_mag(acc_q[W-1] ^ x[W-1], mprod[2*W-1:F]);
	end

	always_ff @(posedge clk) begin
		unique case (req.op)
			OP_NONE: ;
			OP_LOAD: acc_q <= req.coef;
			OP_MUL: prod_q <= mul_res;
			OP_ADD: acc_q <= sat_add(prod_q, req.coef);
			default: ;
		endcase
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

>>> rtl/npr_div.sv
// Restoring radix-2 divider: saturated Q16.16 quotient, one bit per cycle.
`default_nettype none
module npr_div
	import npr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire word_t num,
	input wire word_t den,
	output logic busy,
	output logic done,
	output word_t quo
);
	localparam int CW = $clog2(DW);

	logic busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] sh_q;
	logic [W-1:0] rem_q, ud_q;
	word_t quo_q;
	logic [W:0] trial;
	logic qb;
	logic [DW-1:0] sh_next;

	always_comb begin
		trial = {rem_q, sh_q[DW-1]};
		qb = (trial >= {1'b0, ud_q});
		sh_next = {sh_q[DW-2:0], qb};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			ud_q <= mag_of(den);
			sh_q <= {mag_of(num), {F{1'b0}}};
			rem_q <= '0;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			rem_q <= qb ? W'(trial - {1'b0, ud_q}) : trial[W-1:0];
			sh_q <= sh_next;
			if (cnt_q == '0) quo_q <= from_mag(neg_q, sh_next);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

>>> rtl/newton_polynomial_root_core.sv
// Top level: Newton-Raphson root search of a quartic polynomial over one interval.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the five
//    coefficients (Q16.16), max_iterations, step_tolerance and derivative_floor.
//    cfg_ready is always high; write only while the block is idle.
//  - in channel takes one interval (interval_low, interval_high). in_ready is
//    high only while the sequencer is idle.
//  - out channel returns root, steps_taken and status for each interval.
// Each Newton step runs a derivative Horner pass and then a value Horner pass
// on the shared multiply-add unit, each with its decision state, then the
// one-bit-per-cycle divider, then the update and checks; a setup pass on
// the derivative at the midpoint comes before the first step.
// The core works on one interval at a time; the divider and the shared unit set its pace.
// Reset clears the sequencer and output valid, and loads register defaults.
// A stalled receiver holds the result in the output register; the next
// interval is accepted meanwhile, and its result waits until the slot frees.
`default_nettype none
module newton_polynomial_root_core
	import npr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [31:0] interval_low,
	input wire logic signed [31:0] interval_high,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] root,
	output logic [7:0] steps_taken,
	output logic [1:0] status
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LOAD = 10'b0000000010,
		S_MUL = 10'b0000000100,
		S_ADD = 10'b0000001000,
		S_EVAL = 10'b0000010000,
		S_LIMIT = 10'b0000100000,
		S_DIV = 10'b0001000000,
		S_SUB = 10'b0010000000,
		S_CHECK = 10'b0100000000,
		S_FINISH = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	word_t coef_q [DEG+1];
	logic [CNT_W-1:0] maxit_q;
	logic [W-2:0] tol_q, floor_q;

	// Working registers
	word_t dc_q [DEG];
	word_t lo_q, hi_q, x_q, x1_q, d_q;
	logic [CNT_W-1:0] it_q;
	logic [1:0] idx_q;
	logic deriv_q, first_q;
	status_t st_q;

	// Output register
	logic out_valid_q;
	word_t root_q;
	logic [CNT_W-1:0] steps_q;
	status_t status_q;

	mac_req_t mreq;
	word_t acc;
	logic div_start, div_busy, div_done;
	word_t quo;

	logic in_acc;
	logic signed [W:0] mid_sum;
	logic signed [W:0] dx;
	logic [W:0] diff;
	logic out_load;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign mid_sum = (W+1)'(interval_low) + (W+1)'(interval_high);
	assign dx = (W+1)'(x1_q) - (W+1)'(x_q);
	assign diff = dx[W] ? (~dx + 1'b1) : dx;
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// Request to the shared multiply-add unit
	always_comb begin
		mreq.op = OP_NONE;
		mreq.coef = deriv_q ? dc_q[idx_q] : coef_q[idx_q];
		unique case (state_q)
			S_LOAD: begin
				mreq.op = OP_LOAD;
				mreq.coef = deriv_q ? dc_q[DEG-1] : coef_q[DEG];
			end
			S_MUL: mreq.op = OP_MUL;
			S_ADD: mreq.op = OP_ADD;
			default: mreq.op = OP_NONE;
		endcase
	end

	assign div_start = (state_q == S_EVAL) && !deriv_q;

	npr_mac u_mac (
		.clk(clk),
		.req(mreq),
		.x(x_q),
		.acc(acc)
	);

	npr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(acc),
		.den(d_q),
		.busy(div_busy),
		.done(div_done),
		.quo(quo)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DEG; k++) coef_q[k] <= '0;
			maxit_q <= CNT_W'(100);
			tol_q <= (W-1)'(1);
			floor_q <= (W-1)'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF0: coef_q[0] <= cfg_data;
				REG_COEF1: coef_q[1] <= cfg_data;
				REG_COEF2: coef_q[2] <= cfg_data;
				REG_COEF3: coef_q[3] <= cfg_data;
				REG_COEF4: coef_q[4] <= cfg_data;
				REG_MAXIT: maxit_q <= cfg_data[CNT_W-1:0];
				REG_TOL: tol_q <= cfg_data[W-2:0];
				REG_FLOOR: floor_q <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			deriv_q <= 1'b0;
			first_q <= 1'b0;
			idx_q <= '0;
			it_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					deriv_q <= 1'b1;
					first_q <= 1'b1;
					it_q <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					idx_q <= deriv_q ? 2'(DEG - 2) : 2'(DEG - 1);
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (idx_q == '0) state_q <= S_EVAL;
					else begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_MUL;
					end
				end
				S_EVAL: begin
					if (deriv_q && first_q) begin
						first_q <= 1'b0;
						state_q <= S_LIMIT;
					end else if (deriv_q) begin
						if (acc == '0 || mag_of(acc) < {1'b0, floor_q}) state_q <= S_FINISH;
						else begin
							deriv_q <= 1'b0;
							state_q <= S_LOAD;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_LIMIT: begin
					if (it_q >= maxit_q) state_q <= S_FINISH;
					else begin
						deriv_q <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_DIV: if (div_done) state_q <= S_SUB;
				S_SUB: state_q <= S_CHECK;
				S_CHECK: begin
					if (diff < {2'b0, tol_q}) state_q <= S_FINISH;
					else if (x1_q < lo_q || x1_q > hi_q) state_q <= S_FINISH;
					else begin
						it_q <= it_q + 1'b1;
						state_q <= S_LIMIT;
					end
				end
				S_FINISH: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Estimate and status datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_acc) begin
				lo_q <= interval_low;
				hi_q <= interval_high;
				x_q <= mid_sum[W:1];
				dc_q[0] <= coef_q[1];
				dc_q[1] <= clamp_wide((W+2)'(coef_q[2]) + (W+2)'(coef_q[2]));
				dc_q[2] <= clamp_wide((W+2)'(coef_q[3]) + (W+2)'(coef_q[3])
					+ (W+2)'(coef_q[3]));
				dc_q[3] <= clamp_wide((W+2)'(coef_q[4]) <<< 2);
			end
			S_EVAL: begin
				if (deriv_q && first_q) begin
					if (acc == '0) begin
						x_q <= lo_q;
						x1_q <= lo_q;
					end else begin
						x1_q <= x_q;
					end
				end else if (deriv_q) begin
					d_q <= acc;
					st_q <= ST_FLAT;
				end
			end
			S_LIMIT: st_q <= ST_LIMIT;
			S_SUB: x1_q <= clamp_wide((W+2)'(x_q) - (W+2)'(quo));
			S_CHECK: begin
				if (diff < {2'b0, tol_q}) st_q <= ST_CONV;
				else begin
					x_q <= x1_q;
					st_q <= ST_LEFT;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			root_q <= x1_q;
			steps_q <= it_q;
			status_q <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign root = root_q;
	assign steps_taken = steps_q;
	assign status = status_q;

	// Checks
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_LOAD) && deriv_q && first_q)
		else $error("item start did not enter derivative evaluation");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_busy || div_done))
		else $error("waiting on an idle divider");
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (it_q <= maxit_q))
		else $error("step count above iteration limit");
endmodule
`default_nettype wire

>>> tb/newton_polynomial_root_core_test.sv
// Testbench for newton_polynomial_root_core: directed table, then random configs and intervals.
`timescale 1ns / 100ps
module newton_polynomial_root_core_test;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 80000;
	localparam int N_RANDOM = 930;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = npr_pkg::REG_COEF0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] interval_low = '0;
	logic signed [31:0] interval_high = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] root;
	logic [7:0] steps_taken;
	logic [1:0] status;

	newton_polynomial_root_core dut (.*);

	always #1 clk = ~clk;

	// one expected result per accepted interval
	typedef struct packed {
		logic [31:0] root;
		logic [7:0] steps;
		npr_pkg::status_t st;
	} root_result_t;

	root_result_t pending_roots[$];
	int mismatches = 0;
	int idle_cycles = 0;

	// predictor copy of the registers
	longint coef_q[5];
	int iter_limit;
	longint step_tol;
	longint deriv_floor;

	function automatic longint clampw(longint v);
		return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
	endfunction

	function automatic logic [63:0] magn(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_of(bit neg, logic [63:0] m);
		if (neg)
			return m >= 64'h8000_0000 ? QMIN : -longint'(m);
		return m > 64'h7FFF_FFFF ? QMAX : longint'(m);
	endfunction

	function automatic longint q_add(longint a, longint b);
		return clampw(a + b);
	endfunction

	// Q16.16 multiply, truncated toward zero, saturated
	function automatic longint q_mul(longint a, longint b);
		logic [63:0] p;
		p = magn(a) * magn(b);
		return signed_of((a < 0) != (b < 0), p >> 16);
	endfunction

	// Q16.16 divide; zero divisor gives zero
	function automatic longint q_div(longint y, longint d);
		logic [63:0] q;
		if (d == 0)
			return 0;
		q = (magn(y) << 16) / magn(d);
		return signed_of((y < 0) != (d < 0), q);
	endfunction

	function automatic longint horner_eval(longint c[5], int top, longint x);
		longint acc;
		acc = c[top];
		for (int k = top - 1; k >= 0; k--)
			acc = q_add(q_mul(acc, x), c[k]);
		return acc;
	endfunction

	// Newton search over one interval with the current registers
	function automatic root_result_t solve_root(logic signed [31:0] lo32,
			logic signed [31:0] hi32);
		longint c[5], dc[5];
		longint lo, hi, s, x, x1, y, d;
		logic [63:0] diff;
		int it;
		root_result_t r;
		lo = lo32;
		hi = hi32;
		for (int k = 0; k < 5; k++) begin
			c[k] = clampw(coef_q[k]);
			dc[k] = 0;
		end
		for (int k = 0; k < 4; k++)
			for (int j = 0; j <= k; j++)
				dc[k] = q_add(dc[k], c[k + 1]);
		s = lo + hi;
		x = (s - (s & 1)) / 2;
		if (horner_eval(dc, 3, x) == 0)
			x = lo;
		x1 = x;
		it = 0;
		r.st = npr_pkg::ST_LIMIT;
		while (it < iter_limit) begin
			y = horner_eval(c, 4, x);
			d = horner_eval(dc, 3, x);
			if (d == 0 || magn(d) < 64'(deriv_floor)) begin
				r.st = npr_pkg::ST_FLAT;
				break;
			end
			x1 = clampw(x - q_div(y, d));
			diff = x1 >= x ? 64'(x1 - x) : 64'(x - x1);
			if (diff < 64'(step_tol)) begin
				r.st = npr_pkg::ST_CONV;
				break;
			end
			x = x1;
			if (x1 < lo || x1 > hi) begin
				r.st = npr_pkg::ST_LEFT;
				break;
			end
			it++;
		end
		r.root = x1[31:0];
		r.steps = it[7:0];
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// register write, mirrored into the predictor; valid stays up for the next write
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			npr_pkg::REG_MAXIT: iter_limit = val[7:0];
			npr_pkg::REG_TOL: step_tol = val[30:0];
			npr_pkg::REG_FLOOR: deriv_floor = val[30:0];
			default: coef_q[idx] = longint'(signed'(val));
		endcase
	endtask

	task automatic write_all(logic [31:0] v[8]);
		for (int i = 0; i < 8; i++)
			write_reg(3'(i), v[i]);
		cfg_valid <= 1'b0;
	endtask

	// hand one interval over; valid stays up when no gap follows
	task automatic send_interval(logic [31:0] lo, logic [31:0] hi, bit typed,
			root_result_t typed_res);
		int gap;
		root_result_t r;
		in_valid <= 1'b1;
		interval_low <= lo;
		interval_high <= hi;
		do @(posedge clk); while (!in_ready);
		r = solve_root(lo, hi);
		if (typed && r != typed_res) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with predictor: lo=%h hi=%h", lo, hi);
		end
		pending_roots.push_back(typed ? typed_res : r);
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// receiver stalls: mostly short, sometimes long, with ready runs between
	int hold = 0;
	always @(posedge clk) begin
		if (hold > 0) begin
			hold <= hold - 1;
		end else begin
			out_ready <= ~out_ready;
			hold <= out_ready ? gap_len() : ($urandom_range(3) == 0 ? 30 : $urandom_range(6));
		end
	end

	// result checker
	always @(posedge clk) begin
		root_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_roots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result root=%h steps=%0d status=%0d",
						root, steps_taken, status);
			end else begin
				e = pending_roots.pop_front();
				if (root !== e.root || steps_taken !== e.steps || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp root=%h steps=%0d status=%0d,",
							e.root, e.steps, e.st,
							" got root=%h steps=%0d status=%0d",
							root, steps_taken, status);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// directed table
	typedef struct {
		int phase;
		logic [31:0] lo;
		logic [31:0] hi;
		bit typed;
		root_result_t res;
	} dir_row_t;

	localparam root_result_t NONE = '{32'h0, 8'd0, npr_pkg::ST_CONV};

	dir_row_t dir_rows[] = '{
		// zero polynomial after reset: flat at once, start falls back to low
		'{0, 32'h0001_0000, 32'h0003_0000, 1, '{32'h0001_0000, 8'd0, npr_pkg::ST_FLAT}},
		'{0, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h8000_0000, 8'd0, npr_pkg::ST_FLAT}},
		'{0, 32'h7FFF_FFFF, 32'h8000_0000, 1, '{32'h7FFF_FFFF, 8'd0, npr_pkg::ST_FLAT}},
		// x^2 - 2 with zero step limit: root is the midpoint
		'{1, 32'h0000_0000, 32'h0004_0000, 1, '{32'h0002_0000, 8'd0, npr_pkg::ST_LIMIT}},
		'{1, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'hFFFF_FFFF, 8'd0, npr_pkg::ST_LIMIT}},
		// normal search: converge, leave, reversed, zero derivative at midpoint
		'{2, 32'h0000_0000, 32'h0004_0000, 0, NONE},
		'{2, 32'h0000_0000, 32'h0001_0000, 0, NONE},
		'{2, 32'h0004_0000, 32'h0000_0000, 0, NONE},
		'{2, 32'hFFFC_0000, 32'h0004_0000, 0, NONE},
		'{2, 32'hFFFC_0000, 32'hFFFF_0000, 0, NONE},
		'{2, 32'h8000_0000, 32'h7FFF_FFFF, 0, NONE},
		'{2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, NONE},
		// huge tolerance: converged on the first step
		'{3, 32'h0000_0000, 32'h0004_0000, 0, NONE},
		'{3, 32'h8000_0000, 32'h8000_0000, 0, NONE},
		// huge floor: flat at the midpoint
		'{4, 32'h0000_0000, 32'h0004_0000, 1, '{32'h0002_0000, 8'd0, npr_pkg::ST_FLAT}},
		// saturating quartic
		'{5, 32'h8000_0000, 32'h7FFF_FFFF, 0, NONE},
		'{5, 32'hFFFF_0000, 32'h0001_0000, 0, NONE},
		'{5, 32'h0000_0001, 32'h0000_0002, 0, NONE},
		'{5, 32'h7FFF_0000, 32'h7FFF_FFFF, 0, NONE}
	};

	logic [31:0] dir_cfg[6][8] = '{
		'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd100, 32'd1, 32'd1},
		'{32'hFFFE_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'd0, 32'd1, 32'd1},
		'{32'hFFFE_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'd100, 32'd1, 32'd1},
		'{32'hFFFE_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'd100, 32'h7FFF_FFFF, 32'd1},
		'{32'hFFFE_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'd100, 32'd1, 32'h7FFF_FFFF},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd20, 32'd0, 32'd0}
	};

	function automatic logic [31:0] rand_coef();
		int p;
		p = $urandom_range(99);
		if (p < 10) return $urandom();
		if (p < 15) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		if (p < 30) return 32'h0;
		// small coefficients keep roots in reach
		return 32'(signed'($urandom_range(6 << 16)) - (3 << 16));
	endfunction

	function automatic logic [31:0] rand_thresh(bit wide);
		int p;
		p = $urandom_range(99);
		if (p < 8) return 32'h7FFF_FFFF;
		if (p < 16 && wide) return 32'd0;
		if (p < 25) return {1'b0, 31'($urandom())};
		return $urandom_range(64);
	endfunction

	int cur_phase;
	int items_left;
	int phase_items;
	logic [31:0] rc[8];
	logic [31:0] a, b;

	initial begin
		coef_q = '{0, 0, 0, 0, 0};
		iter_limit = 100;
		step_tol = 1;
		deriv_floor = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		cur_phase = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].phase != cur_phase) begin
				drain();
				cur_phase = dir_rows[i].phase;
				write_all(dir_cfg[cur_phase]);
			end
			send_interval(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].typed, dir_rows[i].res);
		end

		// random phases, each with its own register setting
		items_left = N_RANDOM;
		while (items_left > 0) begin
			drain();
			for (int k = 0; k < 5; k++)
				rc[k] = rand_coef();
			case ($urandom_range(9))
				0: rc[5] = 0;
				1: rc[5] = 255;
				default: rc[5] = $urandom_range(8, 1);
			endcase
			rc[6] = rand_thresh(rc[5] != 255);
			rc[7] = rand_thresh(1);
			if (rc[5] == 255 && rc[6] == 0)
				rc[6] = 1;
			write_all(rc);
			phase_items = rc[5] == 255 ? 4 : $urandom_range(90, 40);
			for (int n = 0; n < phase_items && items_left > 0; n++) begin
				case ($urandom_range(9))
					0, 1: begin
						a = $urandom();
						b = $urandom();
					end
					2: begin
						a = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
						b = $urandom_range(1) ? 32'h7FFF_FFFF : $urandom();
					end
					default: begin
						// interval near the origin, ordered but now and then swapped
						a = 32'(signed'($urandom_range(1 << 20)) - (1 << 19));
						b = a + $urandom_range(1 << 19);
						if ($urandom_range(15) == 0) {a, b} = {b, a};
					end
				endcase
				send_interval(a, b, 0, NONE);
				items_left--;
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_roots.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
